[src/ces_pkg.sv]
// Chebyshev series evaluator: shared types and constants.
// Used by the multiplier, the coefficient RAM users and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ces_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOP_DEGREE     = 2'd0;
    localparam logic [1:0] CFG_SERIES_PRESENT = 2'd1;
    localparam logic [1:0] CFG_MAP_SCALE      = 2'd2;
    localparam logic [1:0] CFG_MAP_OFFSET     = 2'd3;

    // Input item kinds (carried on tuser)
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Recurrence registers are Q46.16, 62 bits signed
    localparam int B_WIDTH   = 62;
    localparam int ACC_WIDTH = 94;   // exact t*b product
    localparam int CB_WIDTH  = 63;   // c - b2
    localparam int SUM_WIDTH = 64;   // m - b2 + c

    localparam logic signed [B_WIDTH-1:0] B_MAX = {1'b0, {(B_WIDTH-1){1'b1}}};
    localparam logic signed [B_WIDTH-1:0] B_MIN = {1'b1, {(B_WIDTH-1){1'b0}}};
    localparam logic signed [31:0]        W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]        W_MIN = 32'sh8000_0000;

    // Q16.16 fraction bits; shifts applied to t*b (factor 2 folded into the step shift)
    localparam int Q16_SHIFT  = 16;
    localparam int SH_STEP    = 15;
    localparam int SH_FINAL   = 16;
    localparam int B_LO_WIDTH = 31;  // b1 split point for the two partial products

    localparam logic signed [31:0] MAP_SCALE_RESET = 32'sd65536;

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

[src/ces_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the coefficient store; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ces_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/ces_mul.sv]
// Shared 32x32 signed multiplier with registered product.
// Depends on ces_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none

module ces_mul (
    input  wire logic              i_clk,
    input  wire ces_pkg::t_mul_req i_req,
    output logic signed [63:0]     o_prod
);

    import ces_pkg::*;

    logic signed [63:0] n_prod;

    assign n_prod = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            o_prod <= n_prod;
        end
    end

endmodule

`default_nettype wire

[src/chebyshev_series_evaluator_top.sv]
// Chebyshev series evaluator top level: sequencer, recurrence datapath, output register.
// Depends on ces_pkg, ces_mul and ces_ram.
//
// Usage:
//   Input stream (i_s_*): tuser is the mode. A write transaction (mode 0) stores
//   coeff_value at coeff_index and gives no result. An evaluate transaction (mode 1)
//   maps x to t and runs the Clenshaw recurrence from top_degree down to 0, then
//   returns one result on the output stream (o_m_*). Each term uses the single 32x32
//   multiplier for two partial products of t*b1, then one accumulate/shift/saturate
//   step and one add/clamp step. With series_present 0 the result is zero. One item
//   is worked on at a time; o_s_tready is high only between items.
//   Configuration port (i_cfg_*): always ready; write only while the block is idle.
//   Reset (synchronous, active low) clears the sequencer, the output valid and the
//   configuration registers; the coefficient store is undefined until written.
//   A stalled receiver holds the result in the output register; the next item is
//   still accepted and computed, and waits for the register before finishing.
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_series_evaluator_top #(
    parameter int MAX_TERMS   = 128,
    parameter int COEFF_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // coeff_index[6:0], coeff_value[38:7], x_value[70:39]
    input  wire logic        i_s_tuser,   // mode
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // y_value[31:0]
    output logic             o_m_tuser,   // saturated
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    import ces_pkg::*;

    localparam int AW = $clog2(MAX_TERMS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_TSET = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_MHI  = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_UPD  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    // input fields
    logic [6:0]         w_coeff_index;
    logic signed [31:0] w_coeff_value;
    logic signed [31:0] w_x_value;
    logic               w_accept;

    assign w_coeff_index = i_s_tdata[6:0];
    assign w_coeff_value = signed'(i_s_tdata[38:7]);
    assign w_x_value     = signed'(i_s_tdata[70:39]);
    assign w_accept      = i_s_tvalid && o_s_tready;

    // configuration
    logic [6:0]         r_top_degree;
    logic               r_series_present;
    logic signed [31:0] r_map_scale;
    logic signed [31:0] r_map_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_degree     <= '0;
            r_series_present <= 1'b0;
            r_map_scale      <= MAP_SCALE_RESET;
            r_map_offset     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TOP_DEGREE:     r_top_degree     <= i_cfg_data[6:0];
                CFG_SERIES_PRESENT: r_series_present <= i_cfg_data[0];
                CFG_MAP_SCALE:      r_map_scale      <= signed'(i_cfg_data);
                CFG_MAP_OFFSET:     r_map_offset     <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // control registers
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic          r_out_valid, n_out_valid;
    logic          w_out_free;

    // datapath registers
    logic signed [31:0]          r_x;
    logic signed [31:0]          r_t;
    logic signed [B_WIDTH-1:0]   r_b1, r_b2, r_m;
    logic signed [63:0]          r_plo;
    logic signed [CB_WIDTH-1:0]  r_cb;
    logic                        r_sat;
    logic signed [31:0]          r_res;
    logic                        r_res_sat;
    logic signed [31:0]          r_y;
    logic                        r_y_sat;

    // shared multiplier
    t_mul_req           w_mul_req;
    logic signed [63:0] w_prod;

    ces_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // coefficient store
    logic                          w_ram_we;
    logic [AW-1:0]                 w_ram_waddr;
    logic [COEFF_WIDTH-1:0]        w_ram_wdata;
    logic                          w_ram_re;
    logic [COEFF_WIDTH-1:0]        w_ram_rdata;
    logic signed [COEFF_WIDTH-1:0] w_coef;

    assign w_ram_we    = w_accept && (i_s_tuser == MODE_WRITE)
                         && (int'(w_coeff_index) < MAX_TERMS);
    assign w_ram_waddr = AW'(w_coeff_index);
    assign w_ram_wdata = COEFF_WIDTH'(w_coeff_value);
    assign w_ram_re    = (r_state == ST_MLO);
    assign w_coef      = signed'(w_ram_rdata);

    ces_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (MAX_TERMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_k),
        .o_rdata (w_ram_rdata)
    );

    // effective top degree
    logic [AW-1:0] w_top;
    assign w_top = (int'(r_top_degree) > MAX_TERMS - 1) ? AW'(MAX_TERMS - 1)
                                                        : AW'(r_top_degree);

    // t = floor(x*scale / 2^16) - offset, clamped to 32 bits
    logic signed [63:0] w_tfl, w_tdiff;
    logic               w_t_hi, w_t_lo;
    assign w_tfl   = w_prod >>> Q16_SHIFT;
    assign w_tdiff = w_tfl - 64'(r_map_offset);
    assign w_t_hi  = w_tdiff > 64'(W_MAX);
    assign w_t_lo  = w_tdiff < 64'(W_MIN);

    // exact t*b1 from the two partial products, then floor shift and 62-bit clamp
    logic signed [ACC_WIDTH-1:0] w_acc, w_shf;
    logic                        w_final, w_low_zero, w_m_hi, w_m_lo;
    assign w_final    = (r_k == '0);
    assign w_acc      = ACC_WIDTH'(r_plo) + (ACC_WIDTH'(w_prod) <<< B_LO_WIDTH);
    assign w_shf      = w_final ? (w_acc >>> SH_FINAL) : (w_acc >>> SH_STEP);
    assign w_low_zero = w_final ? (w_acc[SH_FINAL-1:0] == '0) : (w_acc[SH_STEP-1:0] == '0);
    assign w_m_hi     = w_shf > ACC_WIDTH'(B_MAX);
    // a negative product whose magnitude reaches 2^61 exactly also counts as clipped
    assign w_m_lo     = (w_shf < ACC_WIDTH'(B_MIN))
                        || ((w_shf == ACC_WIDTH'(B_MIN)) && w_low_zero);

    // m - b2 + c
    logic signed [SUM_WIDTH-1:0] w_sum;
    logic                        w_b_hi, w_b_lo, w_y_hi, w_y_lo;
    assign w_sum  = SUM_WIDTH'(r_m) + SUM_WIDTH'(r_cb);
    assign w_b_hi = w_sum > SUM_WIDTH'(B_MAX);
    assign w_b_lo = w_sum < SUM_WIDTH'(B_MIN);
    assign w_y_hi = w_sum > SUM_WIDTH'(W_MAX);
    assign w_y_lo = w_sum < SUM_WIDTH'(W_MIN);

    assign w_out_free = !r_out_valid || i_m_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        w_mul_req   = '{en: 1'b0, a: '0, b: '0};

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_tuser == MODE_EVAL)) begin
                    n_state = r_series_present ? ST_MAP : ST_OUT;
                end
            end
            ST_MAP: begin
                w_mul_req = '{en: 1'b1, a: r_x, b: r_map_scale};
                n_k       = w_top;
                n_state   = ST_TSET;
            end
            ST_TSET: n_state = ST_MLO;
            ST_MLO: begin
                w_mul_req = '{en: 1'b1, a: r_t, b: signed'({1'b0, r_b1[B_LO_WIDTH-1:0]})};
                n_state   = ST_MHI;
            end
            ST_MHI: begin
                w_mul_req = '{en: 1'b1, a: r_t,
                              b: signed'({r_b1[B_WIDTH-1], r_b1[B_WIDTH-1:B_LO_WIDTH]})};
                n_state   = ST_ACC;
            end
            ST_ACC: n_state = ST_UPD;
            ST_UPD: begin
                if (w_final) begin
                    n_state = ST_OUT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = ST_MLO;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x       <= w_x_value;
                r_res     <= '0;
                r_res_sat <= 1'b0;
            end
            ST_MAP: begin
                r_b1  <= '0;
                r_b2  <= '0;
                r_sat <= 1'b0;
            end
            ST_TSET: begin
                if (w_t_hi) begin
                    r_t <= W_MAX;
                end else if (w_t_lo) begin
                    r_t <= W_MIN;
                end else begin
                    r_t <= w_tdiff[31:0];
                end
                r_sat <= w_t_hi || w_t_lo;
            end
            ST_MLO: ;
            ST_MHI: begin
                r_plo <= w_prod;
                r_cb  <= CB_WIDTH'(w_coef) - CB_WIDTH'(r_b2);
            end
            ST_ACC: begin
                if (w_m_hi) begin
                    r_m <= B_MAX;
                end else if (w_m_lo) begin
                    r_m <= B_MIN;
                end else begin
                    r_m <= w_shf[B_WIDTH-1:0];
                end
                r_sat <= r_sat || w_m_hi || w_m_lo;
            end
            ST_UPD: begin
                if (w_final) begin
                    if (w_y_hi) begin
                        r_res <= W_MAX;
                    end else if (w_y_lo) begin
                        r_res <= W_MIN;
                    end else begin
                        r_res <= w_sum[31:0];
                    end
                    r_res_sat <= r_sat || w_y_hi || w_y_lo;
                end else begin
                    r_b2 <= r_b1;
                    if (w_b_hi) begin
                        r_b1 <= B_MAX;
                    end else if (w_b_lo) begin
                        r_b1 <= B_MIN;
                    end else begin
                        r_b1 <= w_sum[B_WIDTH-1:0];
                    end
                    r_sat <= r_sat || w_b_hi || w_b_lo;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_y     <= r_res;
                    r_y_sat <= r_res_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_y;
    assign o_m_tuser  = r_y_sat;

endmodule

`default_nettype wire
